// ----- src/bwme_pkg.sv -----
// Shared types, codes and helpers of the bitmap wall mesh extractor.
package bwme_pkg;

    localparam int MAX_W   = 64;
    localparam int MAX_H   = 64;
    localparam int DIM_W   = 7;
    localparam int COORD_W = 6;
    localparam int ADDR_W  = 12;
    localparam int PIX_N   = MAX_W * MAX_H;
    localparam int IDX_W   = 16;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        PH_LOAD  = 2'd0,
        PH_VERT  = 2'd1,
        PH_HWALL = 2'd2,
        PH_VWALL = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_VERTEX = 2'd0,
        KIND_HWALL  = 2'd1,
        KIND_VWALL  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_PULL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WALL_H = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic pull_start;
        logic wrap;
        logic rd_center;
        logic step;
        logic zero_idx;
        logic nb_init;
        logic nb_step;
        logic set_vert;
        logic run_init;
        logic rd_probe;
        logic probe_inc;
        logic run_skip;
        logic rd_idx_start;
        logic cap_first;
        logic rd_idx_end;
        logic set_wall;
        logic found_none;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic load_done;
        logic pull_search;
        logic scan_end;
        logic cur_ok;
        logic vert_phase;
        logic rd_bit;
        logic nb_last;
        logic keep;
        logic probe_out;
        logic run_long;
        logic out_free;
    } status_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] mx);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) r = DIM_W'(1);
        else if (v > mx) r = mx;
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [COORD_W-1:0] row,
                                                  input logic [COORD_W-1:0] col,
                                                  input logic [DIM_W-1:0] w);
        logic [ADDR_W:0] a;
        a = (ADDR_W+1)'(row) * (ADDR_W+1)'(w) + (ADDR_W+1)'(col);
        return a[ADDR_W-1:0];
    endfunction

    // neighbor k (1..8) as window row / column, 0 = minus one, 2 = plus one
    function automatic logic [1:0] nb_wr(input logic [3:0] k);
        logic [1:0] r;
        case (k)
            4'd1, 4'd2, 4'd3: r = 2'd0;
            4'd6, 4'd7, 4'd8: r = 2'd2;
            default:          r = 2'd1;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] nb_wc(input logic [3:0] k);
        logic [1:0] r;
        case (k)
            4'd1, 4'd4, 4'd6: r = 2'd0;
            4'd3, 4'd5, 4'd8: r = 2'd2;
            default:          r = 2'd1;
        endcase
        return r;
    endfunction

endpackage

// ----- src/bwme_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bwme_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/bwme_ctrl.sv -----
// Sequencer: loads, pulls, the record search and the output hand-off.
module bwme_ctrl
    import bwme_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  logic    command,
    input  status_t st,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CTR,
        ST_NB,
        ST_DECIDE,
        ST_RUN,
        ST_RUNW,
        ST_IDX0,
        ST_IDX1,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   pull_active_reg, pull_active_next;
    state_t finish_state;

    assign finish_state = pull_active_reg ? ST_EMIT : ST_IDLE;
    assign s_tready     = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd              = '0;
        state_next       = state_reg;
        pull_active_next = pull_active_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (command == CMD_LOAD)
                    begin
                        cmd.load = 1'b1;
                        if (st.load_done)
                        begin
                            pull_active_next = 1'b0;
                            state_next       = ST_CHECK;
                        end
                    end
                    else
                    begin
                        cmd.pull_start = 1'b1;
                        if (st.pull_search)
                        begin
                            pull_active_next = 1'b1;
                            state_next       = ST_CHECK;
                        end
                        else
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            ST_CHECK:
            begin
                if (st.scan_end)
                begin
                    cmd.found_none = 1'b1;
                    state_next     = finish_state;
                end
                else if (!st.cur_ok)
                begin
                    cmd.wrap = 1'b1;
                end
                else
                begin
                    cmd.rd_center = 1'b1;
                    state_next    = ST_CTR;
                end
            end
            ST_CTR:
            begin
                if (!st.rd_bit)
                begin
                    cmd.step     = 1'b1;
                    cmd.zero_idx = st.vert_phase;
                    state_next   = ST_CHECK;
                end
                else if (st.vert_phase)
                begin
                    cmd.nb_init = 1'b1;
                    state_next  = ST_NB;
                end
                else
                begin
                    cmd.run_init = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            ST_NB:
            begin
                cmd.nb_step = 1'b1;
                if (st.nb_last)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (st.keep)
                begin
                    cmd.set_vert = 1'b1;
                    state_next   = finish_state;
                end
                else
                begin
                    cmd.zero_idx = 1'b1;
                    cmd.step     = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_RUN, ST_RUNW:
            begin
                if (state_reg == ST_RUN && !st.probe_out)
                begin
                    cmd.rd_probe = 1'b1;
                    state_next   = ST_RUNW;
                end
                else if (state_reg == ST_RUNW && st.rd_bit)
                begin
                    cmd.probe_inc = 1'b1;
                    state_next    = ST_RUN;
                end
                else if (st.run_long)
                begin
                    cmd.rd_idx_start = 1'b1;
                    state_next       = ST_IDX0;
                end
                else
                begin
                    cmd.run_skip = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_IDX0:
            begin
                cmd.cap_first  = 1'b1;
                cmd.rd_idx_end = 1'b1;
                state_next     = ST_IDX1;
            end
            ST_IDX1:
            begin
                cmd.set_wall = 1'b1;
                state_next   = finish_state;
            end
            ST_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            pull_active_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pull_active_reg <= pull_active_next;
        end
    end

endmodule

// ----- src/bwme_dp.sv -----
// Datapath: config, bitmap and index stores, scan cursor, records, output register.
module bwme_dp
    import bwme_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output status_t              st,
    input  logic [7:0]           pixel,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [1:0]           out_kind,
    output logic [COORD_W-1:0]   out_col,
    output logic [COORD_W-1:0]   out_row,
    output logic [15:0]          out_height,
    output logic [IDX_W-1:0]     out_first,
    output logic [IDX_W-1:0]     out_end,
    output logic                 out_last
);

    localparam logic [DIM_W-1:0] MAXW = DIM_W'(MAX_W);
    localparam logic [DIM_W-1:0] MAXH = DIM_W'(MAX_H);

    // configuration
    logic [DIM_W-1:0] cfg_w_reg, cfg_h_reg;
    logic [15:0]      cfg_wh_reg;

    // image and scan control
    logic [DIM_W-1:0]  img_w_reg, img_h_reg;
    logic [ADDR_W-1:0] ptr_reg;
    phase_t            phase_reg;
    logic [DIM_W-1:0]  cur_r_reg, cur_c_reg, pa_reg;
    logic [3:0]        nb_k_reg;
    logic [3:0]        nb_pos_reg;
    logic              nb_ok_reg;
    logic [8:0]        win_reg;
    logic [IDX_W-1:0]  vcnt_reg;
    logic              pend_valid_reg;
    logic              out_valid_reg;

    // record payload
    kind_t             pend_kind_reg, res_kind_reg;
    logic [COORD_W-1:0] pend_col_reg, pend_row_reg, res_col_reg, res_row_reg;
    logic [IDX_W-1:0]  pend_first_reg, pend_end_reg, res_first_reg, res_end_reg;
    logic              res_last_reg;
    kind_t             out_kind_reg;
    logic [COORD_W-1:0] out_col_reg, out_row_reg;
    logic [15:0]       out_height_reg;
    logic [IDX_W-1:0]  out_first_reg, out_end_reg;
    logic              out_last_reg;

    // combinational
    logic [DIM_W-1:0]  eff_w, eff_h;
    logic [13:0]       area;
    logic [ADDR_W:0]   ptr_inc;
    logic              is_vw;
    logic [DIM_W-1:0]  along, lim;
    logic [7:0]        nr, nc;
    logic [1:0]        wr, wc;
    logic              nb_ok;
    logic [3:0]        nb_pos;
    logic [7:0]        rd_row, rd_col;
    logic [ADDR_W-1:0] rd_addr;
    logic              solid_we;
    logic              solid_rd;
    logic              idx_we;
    logic [ADDR_W-1:0] idx_waddr;
    logic [IDX_W-1:0]  idx_wdata;
    logic [IDX_W-1:0]  idx_rd;
    logic [3:0]        n_set;
    logic              border, keep;
    logic              emit_last;
    logic              pend_is_vertex;

    assign eff_w   = (ptr_reg == '0) ? clamp_dim(cfg_w_reg, MAXW) : img_w_reg;
    assign eff_h   = (ptr_reg == '0) ? clamp_dim(cfg_h_reg, MAXH) : img_h_reg;
    assign area    = 14'(eff_w) * 14'(eff_h);
    assign ptr_inc = (ADDR_W+1)'(ptr_reg) + (ADDR_W+1)'(1);

    assign is_vw = (phase_reg == PH_VWALL);
    assign along = is_vw ? cur_r_reg : cur_c_reg;
    assign lim   = is_vw ? img_h_reg : img_w_reg;

    assign wr     = nb_wr(nb_k_reg);
    assign wc     = nb_wc(nb_k_reg);
    assign nr     = {1'b0, cur_r_reg} + 8'(wr) - 8'd1;
    assign nc     = {1'b0, cur_c_reg} + 8'(wc) - 8'd1;
    assign nb_ok  = (nr < {1'b0, img_h_reg}) && (nc < {1'b0, img_w_reg});
    assign nb_pos = 4'(wr) * 4'd3 + 4'(wc);

    // read address select
    always_comb
    begin
        rd_row = {1'b0, cur_r_reg};
        rd_col = {1'b0, cur_c_reg};
        if (cmd.nb_step)
        begin
            rd_row = nr;
            rd_col = nc;
        end
        else if (cmd.rd_probe || cmd.rd_idx_end)
        begin
            if (is_vw)
            begin
                rd_row = cmd.rd_probe ? {1'b0, pa_reg} : {1'b0, pa_reg} - 8'd1;
            end
            else
            begin
                rd_col = cmd.rd_probe ? {1'b0, pa_reg} : {1'b0, pa_reg} - 8'd1;
            end
        end
    end

    assign rd_addr = addr_of(rd_row[COORD_W-1:0], rd_col[COORD_W-1:0], img_w_reg);

    assign solid_we = cmd.load && (phase_reg == PH_LOAD);

    bwme_ram #(
        .WIDTH (1),
        .DEPTH (PIX_N)
    ) u_solid (
        .clk   (clk),
        .we    (solid_we),
        .waddr (ptr_reg),
        .wdata (pixel != 8'd0),
        .raddr (rd_addr),
        .rdata (solid_rd)
    );

    assign pend_is_vertex = (pend_kind_reg == KIND_VERTEX);

    // index map: a kept pixel gets its index at the pull, others are zeroed as visited
    always_comb
    begin
        idx_we    = 1'b0;
        idx_waddr = addr_of(cur_r_reg[COORD_W-1:0], cur_c_reg[COORD_W-1:0], img_w_reg);
        idx_wdata = '0;
        if (cmd.pull_start && phase_reg != PH_LOAD && pend_valid_reg && pend_is_vertex)
        begin
            idx_we    = 1'b1;
            idx_waddr = addr_of(pend_row_reg, pend_col_reg, img_w_reg);
            idx_wdata = vcnt_reg;
        end
        else if (cmd.zero_idx)
        begin
            idx_we = 1'b1;
        end
    end

    bwme_ram #(
        .WIDTH (IDX_W),
        .DEPTH (PIX_N)
    ) u_index (
        .clk   (clk),
        .we    (idx_we),
        .waddr (idx_waddr),
        .wdata (idx_wdata),
        .raddr (rd_addr),
        .rdata (idx_rd)
    );

    // 3x3 rule on the gathered window, outside pixels read as empty
    always_comb
    begin
        n_set = '0;
        for (int i = 0; i < 9; i++)
        begin
            n_set = n_set + 4'(win_reg[i]);
        end
        border = (cur_r_reg == '0) || (cur_c_reg == '0) ||
                 (cur_r_reg == img_h_reg - DIM_W'(1)) ||
                 (cur_c_reg == img_w_reg - DIM_W'(1));
        keep = 1'b1;
        if (border)
        begin
            if (n_set == 4'd3 && ((win_reg[1] && win_reg[7]) || (win_reg[3] && win_reg[5])))
                keep = 1'b0;
        end
        else if (n_set == 4'd3)
        begin
            if ((win_reg[1] && win_reg[7]) || (win_reg[3] && win_reg[5]) ||
                (win_reg[0] && win_reg[8]) || (win_reg[2] && win_reg[6]))
                keep = 1'b0;
        end
        else if (n_set == 4'd5)
        begin
            if (win_reg[1] && win_reg[7] && win_reg[3] && win_reg[5])
                keep = 1'b0;
        end
    end

    assign emit_last = (res_kind_reg == KIND_NONE) ? res_last_reg : !pend_valid_reg;

    always_comb
    begin
        st             = '0;
        st.load_done   = (phase_reg == PH_LOAD) && ({1'b0, ptr_inc} >= area);
        st.pull_search = (phase_reg != PH_LOAD) && pend_valid_reg;
        st.scan_end    = is_vw && (cur_c_reg >= img_w_reg);
        st.cur_ok      = (cur_r_reg < img_h_reg) && (cur_c_reg < img_w_reg);
        st.vert_phase  = (phase_reg == PH_VERT);
        st.rd_bit      = solid_rd;
        st.nb_last     = (nb_k_reg == 4'd9);
        st.keep        = keep;
        st.probe_out   = (pa_reg >= lim);
        st.run_long    = (pa_reg > along + DIM_W'(1));
        st.out_free    = !out_valid_reg || m_tready;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_w_reg      <= MAXW;
            cfg_h_reg      <= MAXH;
            cfg_wh_reg     <= 16'd256;
            img_w_reg      <= DIM_W'(1);
            img_h_reg      <= DIM_W'(1);
            ptr_reg        <= '0;
            phase_reg      <= PH_LOAD;
            cur_r_reg      <= '0;
            cur_c_reg      <= '0;
            pa_reg         <= '0;
            nb_k_reg       <= '0;
            nb_pos_reg     <= '0;
            nb_ok_reg      <= 1'b0;
            win_reg        <= '0;
            vcnt_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_WIDTH:  cfg_w_reg  <= cfg_data[DIM_W-1:0];
                    CFG_HEIGHT: cfg_h_reg  <= cfg_data[DIM_W-1:0];
                    CFG_WALL_H: cfg_wh_reg <= cfg_data;
                    default:    ;
                endcase
            end

            if (cmd.load && phase_reg == PH_LOAD)
            begin
                if (ptr_reg == '0)
                begin
                    img_w_reg <= eff_w;
                    img_h_reg <= eff_h;
                    vcnt_reg  <= '0;
                end
                if (st.load_done)
                begin
                    ptr_reg        <= '0;
                    phase_reg      <= PH_VERT;
                    cur_r_reg      <= '0;
                    cur_c_reg      <= '0;
                    pend_valid_reg <= 1'b0;
                end
                else
                begin
                    ptr_reg <= ptr_inc[ADDR_W-1:0];
                end
            end

            if (cmd.pull_start && st.pull_search && pend_is_vertex)
            begin
                vcnt_reg <= vcnt_reg + IDX_W'(2);
            end

            if (cmd.wrap)
            begin
                if (is_vw)
                begin
                    cur_c_reg <= cur_c_reg + DIM_W'(1);
                    cur_r_reg <= '0;
                end
                else if (cur_r_reg >= img_h_reg)
                begin
                    phase_reg <= (phase_reg == PH_VERT) ? PH_HWALL : PH_VWALL;
                    cur_r_reg <= '0;
                    cur_c_reg <= '0;
                end
                else
                begin
                    cur_r_reg <= cur_r_reg + DIM_W'(1);
                    cur_c_reg <= '0;
                end
            end

            if (cmd.step || cmd.set_vert)
            begin
                if (is_vw) cur_r_reg <= cur_r_reg + DIM_W'(1);
                else       cur_c_reg <= cur_c_reg + DIM_W'(1);
            end

            if (cmd.run_skip || cmd.set_wall)
            begin
                if (is_vw) cur_r_reg <= pa_reg;
                else       cur_c_reg <= pa_reg;
            end

            if (cmd.run_init)  pa_reg <= along + DIM_W'(1);
            if (cmd.probe_inc) pa_reg <= pa_reg + DIM_W'(1);

            if (cmd.nb_init)
            begin
                nb_k_reg <= 4'd1;
                win_reg  <= 9'b000010000;
            end
            if (cmd.nb_step)
            begin
                nb_k_reg   <= nb_k_reg + 4'd1;
                nb_pos_reg <= nb_pos;
                nb_ok_reg  <= nb_ok;
                if (nb_k_reg >= 4'd2)
                begin
                    win_reg[nb_pos_reg] <= nb_ok_reg && solid_rd;
                end
            end

            if (cmd.set_vert || cmd.set_wall) pend_valid_reg <= 1'b1;
            if (cmd.found_none)               pend_valid_reg <= 1'b0;

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                if (emit_last)
                begin
                    phase_reg      <= PH_LOAD;
                    ptr_reg        <= '0;
                    cur_r_reg      <= '0;
                    cur_c_reg      <= '0;
                    pend_valid_reg <= 1'b0;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // record payload
    always_ff @(posedge clk)
    begin
        if (cmd.set_vert)
        begin
            pend_kind_reg  <= KIND_VERTEX;
            pend_col_reg   <= cur_c_reg[COORD_W-1:0];
            pend_row_reg   <= cur_r_reg[COORD_W-1:0];
            pend_first_reg <= '0;
            pend_end_reg   <= '0;
        end
        if (cmd.cap_first)
        begin
            pend_first_reg <= idx_rd;
        end
        if (cmd.set_wall)
        begin
            pend_kind_reg <= is_vw ? KIND_VWALL : KIND_HWALL;
            pend_col_reg  <= cur_c_reg[COORD_W-1:0];
            pend_row_reg  <= cur_r_reg[COORD_W-1:0];
            pend_end_reg  <= idx_rd;
        end

        if (cmd.pull_start)
        begin
            if (st.pull_search)
            begin
                res_kind_reg  <= pend_kind_reg;
                res_col_reg   <= pend_col_reg;
                res_row_reg   <= pend_row_reg;
                res_first_reg <= pend_is_vertex ? vcnt_reg : pend_first_reg;
                res_end_reg   <= pend_end_reg;
                res_last_reg  <= 1'b0;
            end
            else
            begin
                res_kind_reg  <= KIND_NONE;
                res_col_reg   <= '0;
                res_row_reg   <= '0;
                res_first_reg <= '0;
                res_end_reg   <= '0;
                res_last_reg  <= (phase_reg != PH_LOAD);
            end
        end

        if (cmd.emit)
        begin
            out_kind_reg   <= res_kind_reg;
            out_col_reg    <= res_col_reg;
            out_row_reg    <= res_row_reg;
            out_height_reg <= (res_kind_reg == KIND_NONE) ? 16'd0 : cfg_wh_reg;
            out_first_reg  <= res_first_reg;
            out_end_reg    <= res_end_reg;
            out_last_reg   <= emit_last;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_col    = out_col_reg;
    assign out_row    = out_row_reg;
    assign out_height = out_height_reg;
    assign out_first  = out_first_reg;
    assign out_end    = out_end_reg;
    assign out_last   = out_last_reg;

endmodule

// ----- src/bitmap_wall_mesh_extractor.sv -----
// Top level of the bitmap wall mesh extractor.
//
//  channel  direction  tdata / payload                         tuser    tlast
//  s_*      in         pixel[7:0]                              command  -
//  m_*      out        col, row, top_height, first, end (60b)  kind     last
//  cfg_*    in         cfg_index selects register, cfg_data     -        -
//
// A load request stores one pixel; the last pixel of an image also runs the
// search for the first record. A pull request hands off the pending record
// and, if there was one, runs the search for the following record, paced by
// the single read port of the bitmap RAM. No clearing pass after reset.
// Async active-low reset clears control state; a full output register holds the
// next pull result in the hand-off, and the input waits with it.
module bitmap_wall_mesh_extractor
    import bwme_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] pixel
    input  logic [0:0]           s_tuser,   // [0] command
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata,   // [5:0] pos_col, [11:6] pos_row,
                                            // [27:12] top_height, [43:28] first_index,
                                            // [59:44] end_index, [63:60] zero
    output logic [1:0]           m_tuser,   // [1:0] kind
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    cmd_t               cmd;
    status_t            st;
    logic [1:0]         out_kind;
    logic [COORD_W-1:0] out_col, out_row;
    logic [15:0]        out_height;
    logic [IDX_W-1:0]   out_first, out_end;

    assign cfg_ready = 1'b1;

    bwme_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .command  (s_tuser[0]),
        .st       (st),
        .cmd      (cmd)
    );

    bwme_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .pixel      (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .out_kind   (out_kind),
        .out_col    (out_col),
        .out_row    (out_row),
        .out_height (out_height),
        .out_first  (out_first),
        .out_end    (out_end),
        .out_last   (m_tlast)
    );

    assign m_tuser = out_kind;
    assign m_tdata = {4'd0, out_end, out_first, out_height, out_row, out_col};

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for bitmap_wall_mesh_extractor: driver, stall monitor, predictor.
`timescale 1ns / 1ps

module tb_top;
    import bwme_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [63:0]          m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data = '0;

    bitmap_wall_mesh_extractor u_dut (.*);

    always #6 clk = ~clk;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] reg_sel;
        logic [15:0]          value;
        logic                 cmd;
        logic [7:0]           pixel;
    } request_t;

    typedef struct packed {
        kind_t       kind;
        logic [5:0]  col;
        logic [5:0]  row;
        logic [15:0] top;
        logic [15:0] first;
        logic [15:0] fin;
        logic        last;
    } mesh_rec_t;

    request_t  pend_q[$];
    mesh_rec_t mesh_q[$];
    int        mismatches = 0;
    int        rx_count = 0;
    int        sent_items = 0;
    int        quiet_cycles = 0;

    // ---------------- mesh predictor ----------------
    bit          solid_bits[PIX_N];
    logic [15:0] vtx_index[PIX_N];
    int          load_ptr, scan_r, scan_c, img_w, img_h;
    phase_t      scan_phase;
    logic [15:0] vtx_count;
    logic [6:0]  reg_width, reg_height;
    logic [15:0] reg_wall_h;

    function automatic int pix_addr(int r, int c);
        int a;
        a = r * img_w + c;
        return (a < PIX_N) ? a : 0;
    endfunction

    function automatic bit is_solid(int r, int c);
        return solid_bits[pix_addr(r, c)];
    endfunction

    function automatic int fit_dim(int v, int mx);
        if (v < 1) return 1;
        return (v > mx) ? mx : v;
    endfunction

    function automatic bit keeps_vertex(int r, int c);
        int n, r0, r1, c0, c1;
        n = 0;
        if (!is_solid(r, c)) return 0;
        if (r == 0 || c == 0 || r == img_h - 1 || c == img_w - 1) begin
            r0 = (r == 0) ? 0 : r - 1;
            r1 = (r == img_h - 1) ? r : r + 1;
            c0 = (c == 0) ? 0 : c - 1;
            c1 = (c == img_w - 1) ? c : c + 1;
            for (int i = r0; i <= r1; i++)
                for (int j = c0; j <= c1; j++)
                    if (is_solid(i, j)) n++;
            if (n != 3) return 1;
            if (r > 0 && r < img_h - 1 && is_solid(r - 1, c) && is_solid(r + 1, c)) return 0;
            if (c > 0 && c < img_w - 1 && is_solid(r, c - 1) && is_solid(r, c + 1)) return 0;
            return 1;
        end
        for (int i = r - 1; i <= r + 1; i++)
            for (int j = c - 1; j <= c + 1; j++)
                if (is_solid(i, j)) n++;
        if (n == 3) begin
            if (is_solid(r - 1, c) && is_solid(r + 1, c)) return 0;
            if (is_solid(r, c - 1) && is_solid(r, c + 1)) return 0;
            if (is_solid(r - 1, c - 1) && is_solid(r + 1, c + 1)) return 0;
            if (is_solid(r - 1, c + 1) && is_solid(r + 1, c - 1)) return 0;
        end else if (n == 5) begin
            if (is_solid(r - 1, c) && is_solid(r + 1, c) &&
                is_solid(r, c - 1) && is_solid(r, c + 1)) return 0;
        end
        return 1;
    endfunction

    // advance the scan cursor to the next record; 0 when the mesh is exhausted
    function automatic bit next_record(ref phase_t p, ref int r, ref int c,
                                       output mesh_rec_t o);
        int rr, cc, len;
        o = '0;
        while (p != PH_LOAD) begin
            if (p == PH_VERT || p == PH_HWALL) begin
                if (r >= img_h) begin
                    p = phase_t'(p + 1); r = 0; c = 0;
                    continue;
                end
                if (c >= img_w) begin
                    r++; c = 0;
                    continue;
                end
            end else begin
                if (c >= img_w) begin
                    p = PH_LOAD; r = 0; c = 0;
                    return 0;
                end
                if (r >= img_h) begin
                    c++; r = 0;
                    continue;
                end
            end
            rr = r; cc = c;
            o.row = rr[5:0];
            o.col = cc[5:0];
            if (p == PH_VERT) begin
                c++;
                if (keeps_vertex(rr, cc)) begin
                    o.kind = KIND_VERTEX;
                    return 1;
                end
                continue;
            end
            if (!is_solid(rr, cc)) begin
                if (p == PH_HWALL) c++; else r++;
                continue;
            end
            len = 1;
            if (p == PH_HWALL) begin
                while (cc + len < img_w && is_solid(rr, cc + len)) len++;
                if (len > 1) begin
                    c = cc + len;
                    o.kind = KIND_HWALL;
                    o.first = vtx_index[pix_addr(rr, cc)];
                    o.fin = vtx_index[pix_addr(rr, cc + len - 1)];
                    return 1;
                end
                c++;
            end else begin
                while (rr + len < img_h && is_solid(rr + len, cc)) len++;
                if (len > 1) begin
                    r = rr + len;
                    o.kind = KIND_VWALL;
                    o.first = vtx_index[pix_addr(rr, cc)];
                    o.fin = vtx_index[pix_addr(rr + len - 1, cc)];
                    return 1;
                end
                r++;
            end
        end
        return 0;
    endfunction

    function automatic void restart_load();
        scan_phase = PH_LOAD; load_ptr = 0; scan_r = 0; scan_c = 0;
    endfunction

    function automatic void model_reset();
        reg_width = 7'd64; reg_height = 7'd64; reg_wall_h = 16'd256;
        for (int i = 0; i < PIX_N; i++) vtx_index[i] = '0;
        vtx_count = '0; img_w = 1; img_h = 1;
        restart_load();
    endfunction

    function automatic void load_pixel(logic [7:0] pix);
        if (scan_phase != PH_LOAD) return;
        if (load_ptr == 0) begin
            img_w = fit_dim(reg_width, MAX_W);
            img_h = fit_dim(reg_height, MAX_H);
            for (int i = 0; i < PIX_N; i++) vtx_index[i] = '0;
            vtx_count = '0;
        end
        if (load_ptr < PIX_N) solid_bits[load_ptr] = (pix != 0);
        load_ptr++;
        if (load_ptr >= img_w * img_h) begin
            load_ptr = 0; scan_phase = PH_VERT; scan_r = 0; scan_c = 0;
        end
    endfunction

    function automatic mesh_rec_t pull_record();
        mesh_rec_t o, rec, probe;
        phase_t    pp;
        int        pr, pc;
        o = '0;
        o.kind = KIND_NONE;
        if (scan_phase == PH_LOAD) return o;
        if (!next_record(scan_phase, scan_r, scan_c, rec)) begin
            o.last = 1'b1;
            restart_load();
            return o;
        end
        if (rec.kind == KIND_VERTEX) begin
            rec.first = vtx_count;
            vtx_index[pix_addr(rec.row, rec.col)] = vtx_count;
            vtx_count = vtx_count + 16'd2;
        end
        o = rec;
        o.top = reg_wall_h;
        pp = scan_phase; pr = scan_r; pc = scan_c;
        if (!next_record(pp, pr, pc, probe)) begin
            o.last = 1'b1;
            restart_load();
        end
        return o;
    endfunction

    // ---------------- driver ----------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n) begin
        request_t req;
        bit       hold;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            cfg_valid <= 1'b0;
        end else begin
            hold = 0;
            if (s_tvalid && s_tready) begin
                sent_items++;
                if (s_tuser[0] == CMD_PULL) mesh_q = {mesh_q, pull_record()};
                else load_pixel(s_tdata);
            end else if (s_tvalid) begin
                hold = 1;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_WIDTH:  reg_width = cfg_data[6:0];
                    CFG_HEIGHT: reg_height = cfg_data[6:0];
                    CFG_WALL_H: reg_wall_h = cfg_data;
                    default: ;
                endcase
            end
            quiet_cycles = (mesh_q.size() == 0 && !s_tvalid) ? quiet_cycles + 1 : 0;
            if (!hold) begin
                if (pend_q.size() > 0 && pend_q[0].is_cfg) begin
                    s_tvalid <= 1'b0;
                    if ((!cfg_valid || cfg_ready) && quiet_cycles >= 64 && !s_tvalid &&
                        s_tready) begin
                        req = pend_q.pop_front();
                        cfg_index <= req.reg_sel;
                        cfg_data <= req.value;
                        cfg_valid <= 1'b1;
                    end else if (cfg_ready) begin
                        cfg_valid <= 1'b0;
                    end
                end else begin
                    if (cfg_ready) cfg_valid <= 1'b0;
                    if (gap_left > 0) begin
                        gap_left--;
                        s_tvalid <= 1'b0;
                    end else if (pend_q.size() > 0) begin
                        req = pend_q.pop_front();
                        s_tuser <= req.cmd;
                        s_tdata <= req.pixel;
                        s_tvalid <= 1'b1;
                        if (burst_left > 0) burst_left--;
                        else begin
                            burst_left = $urandom_range(0, 30);
                            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                        end
                    end else begin
                        s_tvalid <= 1'b0;
                    end
                end
            end else if (cfg_valid && cfg_ready) begin
                cfg_valid <= 1'b0;
            end
        end
    end

    // ---------------- receiver and checker ----------------
    int  stall_mode = 0;
    int  mode_timer = 0;
    int  long_hold = 0;
    bit  long_done = 0;

    always @(posedge clk or negedge rst_n) begin
        mesh_rec_t want, got;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                rx_count++;
                got.kind = kind_t'(m_tuser);
                got.col = m_tdata[5:0];
                got.row = m_tdata[11:6];
                got.top = m_tdata[27:12];
                got.first = m_tdata[43:28];
                got.fin = m_tdata[59:44];
                got.last = m_tlast;
                if (mesh_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected record %p", got);
                end else begin
                    want = mesh_q.pop_front();
                    if (got !== want || m_tdata[63:60] !== 4'd0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("record mismatch: expected %p got %p", want, got);
                    end
                end
            end
            if (mode_timer == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_timer = $urandom_range(50, 300);
            end else mode_timer--;
            if (long_hold > 0) begin
                long_hold--;
                m_tready <= 1'b0;
            end else if (!long_done && rx_count >= 40) begin
                long_done = 1;
                long_hold = 2000;
                m_tready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ($urandom_range(0, 1) == 1);
                    default: m_tready <= (mode_timer % 8 < 2);
                endcase
            end
        end
    end

    // ---------------- stimulus ----------------
    function automatic void queue_cfg(logic [CFG_IDX_W-1:0] sel, logic [15:0] v);
        request_t q;
        q = '{1'b1, sel, v, CMD_LOAD, 8'd0};
        pend_q = {pend_q, q};
    endfunction

    function automatic void queue_item(logic cmd, logic [7:0] pix);
        request_t q;
        q = '{1'b0, CFG_WIDTH, 16'd0, cmd, pix};
        pend_q = {pend_q, q};
    endfunction

    function automatic logic [7:0] solid_byte();
        return 8'($urandom_range(1, 255));
    endfunction

    // configure, load a whole bitmap (shape chosen by style), then pull the mesh out
    task automatic run_image(int w, int h, logic [15:0] wh, int style, int density);
        int ew, eh;
        bit on;
        queue_cfg(CFG_WIDTH, {9'($urandom_range(0, 511)), w[6:0]});
        queue_cfg(CFG_HEIGHT, {9'($urandom_range(0, 511)), h[6:0]});
        queue_cfg(CFG_WALL_H, wh);
        ew = fit_dim(w[6:0], MAX_W);
        eh = fit_dim(h[6:0], MAX_H);
        repeat ($urandom_range(0, 2)) queue_item(CMD_PULL, 8'($urandom_range(0, 255)));
        for (int r = 0; r < eh; r++)
            for (int c = 0; c < ew; c++) begin
                case (style)
                    1: on = (r == eh / 2) || (c == ew / 2);           // plus shape
                    2: on = (r == c);                                 // diagonal
                    3: on = (r == 0) || (c == 0) || (r == eh - 1) || (c == ew - 1);
                    default: on = ($urandom_range(0, 99) < density);
                endcase
                if ($urandom_range(0, 40) == 0)
                    queue_item(CMD_PULL, 8'($urandom_range(0, 255)));
                queue_item(CMD_LOAD, on ? solid_byte() : 8'd0);
            end
        do @(negedge clk); while (pend_q.size() > 0 || s_tvalid);
        while (scan_phase != PH_LOAD) begin
            if ($urandom_range(0, 7) == 0) queue_item(CMD_LOAD, 8'($urandom_range(0, 255)));
            else queue_item(CMD_PULL, 8'($urandom_range(0, 255)));
            do @(negedge clk); while (pend_q.size() > 0 || s_tvalid);
        end
    endtask

    initial begin
        model_reset();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        // directed: clamped and extreme sizes, rule shapes, empty mesh
        run_image(0, 0, 16'hFFFF, 0, 100);
        run_image(1, 1, 16'h0000, 0, 0);
        run_image(3, 3, 16'h0100, 1, 0);
        run_image(5, 5, 16'h1234, 1, 0);
        run_image(5, 5, 16'h00FF, 2, 0);
        run_image(4, 4, 16'hABCD, 3, 0);
        run_image(127, 2, 16'h8000, 0, 50);
        run_image(3, 127, 16'h7FFF, 0, 60);
        run_image(64, 1, 16'h0001, 0, 70);
        run_image(1, 64, 16'hFFFE, 0, 70);
        run_image(6, 0, 16'h5555, 0, 90);
        // random part
        while (sent_items < 1300) begin
            if ($urandom_range(0, 15) == 0)
                run_image($urandom_range(0, 127), $urandom_range(1, 4),
                          16'($urandom_range(0, 65535)), 0, $urandom_range(0, 100));
            else
                run_image($urandom_range(1, 9), $urandom_range(1, 9),
                          16'($urandom_range(0, 65535)), $urandom_range(0, 5),
                          $urandom_range(0, 100));
        end
        while (mesh_q.size() > 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && mesh_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    int cycle_count = 0;
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > 2000000) begin
            $display("FAIL");
            $finish;
        end
    end

endmodule
